// File: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, operation codes and the request/response types shared by the cache
// datapath and its top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int Entries = 16;
  localparam int RankW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int FillW   = $clog2(Entries + 1);
  localparam int CapW    = 5;
  localparam int KeyW    = 32;
  localparam int ValW    = 31;
  localparam int OutW    = 32;
  localparam int CapReset = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    logic            valid;
    op_e             op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value;
  } rsp_t;

endpackage

// File: sv/lkvc_store.sv
// ----------------------------------------------------------------------------
// LRU key/value cache store
// Register-based CAM with recency ranks. Looks up, refreshes, updates and
// inserts for each request, with a combinational compare and registered state.
// ----------------------------------------------------------------------------
module lkvc_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]  cfg_wdata_i,
  input  lkvc_pkg::req_t             req_i,
  output lkvc_pkg::rsp_t             rsp_o
);

  localparam int N     = lkvc_pkg::Entries;
  localparam int RankW = lkvc_pkg::RankW;
  localparam int FillW = lkvc_pkg::FillW;
  localparam int CapW  = lkvc_pkg::CapW;
  localparam int CmpW  = (FillW > CapW) ? FillW : CapW;

  logic [lkvc_pkg::KeyW-1:0] key_q   [N];
  logic [lkvc_pkg::ValW-1:0] value_q [N];
  logic [N-1:0]              valid_q, valid_d;
  logic [RankW-1:0]          rank_q  [N];
  logic [RankW-1:0]          rank_d  [N];
  logic [FillW-1:0]          fill_q, fill_d;
  logic [CapW-1:0]           cap_q;

  logic [N-1:0]              match;
  logic                      hit;
  logic [RankW-1:0]          hit_rank;
  logic [lkvc_pkg::ValW-1:0] hit_value;
  logic [FillW-1:0]          cap_eff;
  logic [CmpW-1:0]           cap_w;
  logic                      evict;
  logic [N-1:0]              oldest;
  logic [N-1:0]              kept;
  logic [N-1:0]              slot;
  logic                      found;
  logic [N-1:0]              key_we;
  logic [N-1:0]              value_we;

  // A capacity of zero behaves as one; anything above the entry count saturates.
  always_comb begin
    cap_w = CmpW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = FillW'(1);
    end else if (cap_w > CmpW'(N)) begin
      cap_eff = FillW'(N);
    end else begin
      cap_eff = FillW'(cap_w);
    end
  end

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_i.key);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_value = hit_value | value_q[i];
      end
    end
    hit = |match;
  end

  // The valid ranks always form 0 .. fill-1, so the least recent entry is
  // simply the one whose rank equals fill-1.
  always_comb begin
    evict = (fill_q >= cap_eff);
    for (int i = 0; i < N; i++) begin
      oldest[i] = valid_q[i] && (FillW'(rank_q[i]) == (fill_q - FillW'(1)));
    end
    kept  = evict ? (valid_q & ~oldest) : valid_q;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      slot[i] = !kept[i] && !found;
      found   = found | !kept[i];
    end
  end

  always_comb begin
    valid_d  = valid_q;
    fill_d   = fill_q;
    key_we   = '0;
    value_we = '0;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (req_i.valid) begin
      if (hit) begin
        for (int i = 0; i < N; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
        if (req_i.op == lkvc_pkg::OP_SET) begin
          value_we = match;
        end
      end else if ((req_i.op == lkvc_pkg::OP_SET) && found) begin
        valid_d  = kept | slot;
        key_we   = slot;
        value_we = slot;
        fill_d   = fill_q - FillW'(evict) + FillW'(1);
        for (int i = 0; i < N; i++) begin
          if (kept[i]) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end else begin
            rank_d[i] = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapW'(lkvc_pkg::CapReset);
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cap_q   <= cfg_wdata_i;
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (key_we[i]) begin
        key_q[i] <= req_i.key;
      end
      if (value_we[i]) begin
        value_q[i] <= req_i.value;
      end
    end
  end

  assign rsp_o.hit   = hit;
  assign rsp_o.value = hit_value;

endmodule

// File: sv/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key/value cache top level
// Input register, CAM store and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_stall_o with opcode_i, key_i, value_i.
//   A get produces one result transaction on out_valid_o/out_stall_i with
//   hit_o and read_value_o (the stored value, or all ones on a miss); a set
//   produces none.
//   Each accepted transaction is held in the input register and resolved
//   against the store from there; a get result is captured in the result
//   register and presented from it. One transaction can be accepted every
//   cycle while in_stall_o is low; the store's compare and rank update set this.
//   A pending get waits in the input register while the result register is
//   full and stalled, and in_stall_o is raised until the result is taken.
//   Sets are never held by a stalled receiver.
//   Reset empties the store and sets the capacity to sixteen. Writing the
//   capacity through cfg_we_i/cfg_wdata_i empties the store as well; the user
//   must do it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]   key_i,
  input  logic [lkvc_pkg::ValW-1:0]          value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic signed [lkvc_pkg::OutW-1:0]   read_value_o
);

  logic                              pipe_valid_q, pipe_valid_d;
  lkvc_pkg::op_e                     pipe_op_q;
  logic [lkvc_pkg::KeyW-1:0]         pipe_key_q;
  logic [lkvc_pkg::ValW-1:0]         pipe_value_q;
  logic                              proc;
  logic                              accept;
  logic                              out_valid_q, out_valid_d;
  logic                              hit_q;
  logic [lkvc_pkg::OutW-1:0]         read_value_q;
  logic                              load_out;
  lkvc_pkg::req_t                    req;
  lkvc_pkg::rsp_t                    rsp;

  // A get may only be resolved when the result register is free or draining.
  assign proc = pipe_valid_q &&
                ((pipe_op_q == lkvc_pkg::OP_SET) || !out_valid_q || !out_stall_i);
  assign in_stall_o   = pipe_valid_q && !proc;
  assign accept       = in_valid_i && !in_stall_o;
  assign pipe_valid_d = accept || (pipe_valid_q && !proc);
  assign load_out     = proc && (pipe_op_q == lkvc_pkg::OP_GET);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign req.valid = proc;
  assign req.op    = pipe_op_q;
  assign req.key   = pipe_key_q;
  assign req.value = pipe_value_q;

  lkvc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pipe_op_q    <= lkvc_pkg::op_e'(opcode_i);
      pipe_key_q   <= key_i;
      pipe_value_q <= value_i;
    end
    if (load_out) begin
      hit_q        <= rsp.hit;
      read_value_q <= rsp.hit ? {1'b0, rsp.value} : '1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and set transactions with random gaps and receiver stalls,
// predicts every lookup result from a behavioural copy of the store and
// compares each result transaction with the oldest prediction. The capacity
// is rewritten between phases, covering zero, one, sixteen and values above.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    lkvc_pkg::op_e             op;
    logic [lkvc_pkg::KeyW-1:0] key;
    logic [lkvc_pkg::ValW-1:0] value;
  } cache_req_t;

  typedef struct {
    logic                      hit;
    logic [lkvc_pkg::OutW-1:0] data;
  } lookup_rsp_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [lkvc_pkg::CapW-1:0]        cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic                             opcode_i = 1'b0;
  logic signed [lkvc_pkg::KeyW-1:0] key_i = '0;
  logic [lkvc_pkg::ValW-1:0]        value_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic                             hit_o;
  logic signed [lkvc_pkg::OutW-1:0] read_value_o;

  cache_req_t  request_q[$];
  lookup_rsp_t lookup_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_took = 1'b0;

  // Behavioural copy of the store
  logic [lkvc_pkg::KeyW-1:0] model_key[lkvc_pkg::Entries];
  logic [lkvc_pkg::ValW-1:0] model_val[lkvc_pkg::Entries];
  bit                        model_used[lkvc_pkg::Entries];
  int unsigned               model_rank[lkvc_pkg::Entries];
  int unsigned               model_fill;
  logic [lkvc_pkg::CapW-1:0] model_cap;

  lru_key_value_cache_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .read_value_o(read_value_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned cap_in_use(logic [lkvc_pkg::CapW-1:0] c);
    int unsigned n;
    n = c;
    if (n == 0) n = 1;
    if (n > lkvc_pkg::Entries) n = lkvc_pkg::Entries;
    return n;
  endfunction

  function void cache_clear(logic [lkvc_pkg::CapW-1:0] c);
    model_cap = c;
    model_fill = 0;
    for (int i = 0; i < lkvc_pkg::Entries; i++) begin
      model_used[i] = 1'b0;
      model_rank[i] = 0;
      model_key[i] = '0;
      model_val[i] = '0;
    end
  endfunction

  // Moves entry e to the front; entries that were more recent age by one.
  function void cache_touch(int e);
    int unsigned r;
    r = model_rank[e];
    for (int i = 0; i < lkvc_pkg::Entries; i++) begin
      if (model_used[i] && model_rank[i] < r) model_rank[i]++;
    end
    model_rank[e] = 0;
  endfunction

  function void cache_insert(logic [lkvc_pkg::KeyW-1:0] k, logic [lkvc_pkg::ValW-1:0] v);
    int slot;
    int oldest;
    slot = -1;
    oldest = -1;
    if (model_fill >= cap_in_use(model_cap)) begin
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
        if (model_used[i] && (oldest < 0 || model_rank[i] > model_rank[oldest])) oldest = i;
      end
      if (oldest >= 0) begin
        model_used[oldest] = 1'b0;
        model_rank[oldest] = 0;
        model_fill--;
      end
    end
    for (int i = 0; i < lkvc_pkg::Entries; i++) begin
      if (!model_used[i] && slot < 0) slot = i;
    end
    if (slot >= 0) begin
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
        if (model_used[i]) model_rank[i]++;
      end
      model_used[slot] = 1'b1;
      model_key[slot] = k;
      model_val[slot] = v;
      model_rank[slot] = 0;
      model_fill++;
    end
  endfunction

  // Applies one accepted transaction and records the lookup result it causes.
  function void cache_access(cache_req_t r);
    int          e;
    lookup_rsp_t rsp;
    e = -1;
    for (int i = 0; i < lkvc_pkg::Entries; i++) begin
      if (e < 0 && model_used[i] && model_key[i] == r.key) e = i;
    end
    if (r.op == lkvc_pkg::OP_GET) begin
      if (e >= 0) begin
        cache_touch(e);
        rsp.hit = 1'b1;
        rsp.data = {1'b0, model_val[e]};
      end else begin
        rsp.hit = 1'b0;
        rsp.data = '1;
      end
      lookup_q.push_back(rsp);
    end else if (e >= 0) begin
      model_val[e] = r.value;
      cache_touch(e);
    end else begin
      cache_insert(r.key, r.value);
    end
  endfunction

  function void push_req(lkvc_pkg::op_e op, logic [lkvc_pkg::KeyW-1:0] k,
                         logic [lkvc_pkg::ValW-1:0] v);
    cache_req_t r;
    r.op = op;
    r.key = k;
    r.value = v;
    request_q.push_back(r);
  endfunction

  function automatic logic [lkvc_pkg::ValW-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return lkvc_pkg::ValW'($urandom());
    endcase
  endfunction

  // Random traffic over a key pool a little larger than the capacity in use,
  // so that hits, misses, updates and evictions all occur often.
  function void queue_phase(int unsigned n, logic [lkvc_pkg::CapW-1:0] c);
    logic [lkvc_pkg::KeyW-1:0] pool[24];
    int unsigned               pool_sz;
    logic [lkvc_pkg::KeyW-1:0] k;
    pool_sz = cap_in_use(c) + 1 + $urandom_range(3);
    for (int i = 0; i < pool_sz; i++) begin
      case ($urandom_range(7))
        0: pool[i] = 32'h8000_0000;
        1: pool[i] = 32'h7fff_ffff;
        2: pool[i] = '1;
        3: pool[i] = '0;
        default: pool[i] = $urandom();
      endcase
    end
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? lkvc_pkg::KeyW'($urandom())
                                   : pool[$urandom_range(pool_sz - 1)];
      push_req(($urandom_range(99) < 50) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_SET, k,
               pick_value());
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || lookup_q.size() != 0);
    // a trailing set may still sit in the input register
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CapW-1:0] c);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Driver
  always @(negedge clk_i) begin
    cache_req_t cur;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = request_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= cur.op;
        key_i <= cur.key;
        value_i <= cur.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor
  always @(posedge clk_i) begin
    cache_req_t  acc;
    lookup_rsp_t exp_rsp;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && !in_stall_o;
      if (cfg_we_i) cache_clear(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) begin
        acc.op = lkvc_pkg::op_e'(opcode_i);
        acc.key = key_i;
        acc.value = value_i;
        cache_access(acc);
      end
      if (out_valid_o && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          $error("hit: result transaction with none expected, actual hit %0b read_value %h",
                 hit_o, read_value_o);
          mismatch_cnt++;
        end else begin
          exp_rsp = lookup_q.pop_front();
          if (hit_o !== exp_rsp.hit) begin
            $error("hit: expected %0b, actual %0b", exp_rsp.hit, hit_o);
            mismatch_cnt++;
          end
          if (read_value_o !== exp_rsp.data) begin
            $error("read_value: expected %h, actual %h", exp_rsp.data, read_value_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    logic [lkvc_pkg::CapW-1:0] caps[9];
    caps = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd4, 5'd16, 5'd8, 5'd0};
    caps[8] = lkvc_pkg::CapW'($urandom_range(31));
    cache_clear(lkvc_pkg::CapW'(lkvc_pkg::CapReset));
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-store miss, extreme keys and values, update, absent key.
    push_req(lkvc_pkg::OP_GET, '0, '0);
    push_req(lkvc_pkg::OP_SET, 32'h8000_0000, '1);
    push_req(lkvc_pkg::OP_SET, 32'h7fff_ffff, '0);
    push_req(lkvc_pkg::OP_SET, '1, 31'h5555_5555);
    push_req(lkvc_pkg::OP_SET, '0, 31'h2aaa_aaaa);
    push_req(lkvc_pkg::OP_GET, 32'h8000_0000, '1);
    push_req(lkvc_pkg::OP_GET, 32'h7fff_ffff, '0);
    push_req(lkvc_pkg::OP_GET, '1, '0);
    push_req(lkvc_pkg::OP_GET, '0, '1);
    push_req(lkvc_pkg::OP_SET, '1, 31'd1);
    push_req(lkvc_pkg::OP_GET, '1, '0);
    push_req(lkvc_pkg::OP_GET, 32'd12345, '0);
    queue_phase(36, lkvc_pkg::CapW'(lkvc_pkg::CapReset));
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 49; recv_stall_pct = 0; end
        1: begin send_idle_pct = 0; recv_stall_pct = 49; end
        2: begin send_idle_pct = 7; recv_stall_pct = 7; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_capacity(caps[p]);
      queue_phase(40, caps[p]);
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: lru_key_value_cache_top.f
sv/lkvc_pkg.sv
sv/lkvc_store.sv
sv/lru_key_value_cache_top.sv
sim/tb.sv
